### hw/rtl/rwu_pkg.sv
package rwu_pkg;

	// number format
	localparam int VW     = 32;          // signed value width
	localparam int MW     = VW - 1;      // mean-square width
	localparam int FB     = 24;          // fraction bits
	localparam int CW     = 25;          // numeric register width
	localparam int TW     = VW + 2;      // scaled step and decayed momentum
	localparam int RAD_W  = VW + FB;     // radicand width
	localparam int ROOT_W = RAD_W / 2;   // root width
	localparam int RT_W   = RAD_W + 1;   // running root register
	localparam int DEN_W  = ROOT_W + 1;  // divisor width
	localparam int NUM_W  = TW + FB;     // dividend width
	localparam int QW     = VW;          // quotient bits resolved by the chain
	localparam int DIV_W  = DEN_W + QW;  // shifted divisor width

	localparam logic [CW-1:0] ONE_FX = CW'(1) << FB;

	// register indexes
	localparam logic [2:0] CFG_VARIANT  = 3'd0;
	localparam logic [2:0] CFG_LR       = 3'd1;
	localparam logic [2:0] CFG_BETA1    = 3'd2;
	localparam logic [2:0] CFG_BETA2    = 3'd3;
	localparam logic [2:0] CFG_EPS      = 3'd4;
	localparam logic [2:0] CFG_WD       = 3'd5;
	localparam logic [2:0] CFG_ENABLE   = 3'd6;

	typedef struct packed {
		logic signed [VW-1:0] weight_in;
		logic signed [VW-1:0] momentum_in;
		logic [MW-1:0]        mean_square_in;
		logic signed [VW-1:0] gradient_in;
	} item_t;

	typedef struct packed {
		logic signed [VW-1:0] weight_out;
		logic signed [VW-1:0] momentum_out;
		logic [MW-1:0]        mean_square_out;
		logic                 saturated_flag;
	} result_t;

	// per-element context that travels alongside the arithmetic
	typedef struct packed {
		logic signed [VW-1:0] w;
		logic signed [VW-1:0] m;
		logic [MW-1:0]        v;
		logic [MW-1:0]        vn;
		logic signed [TW-1:0] t;
		logic signed [TW-1:0] bm;
		logic                 flag;
	} ctx_t;

	typedef struct packed {
		logic [RAD_W-1:0] rem;
		logic [RT_W-1:0]  root;
	} sqs_t;

	typedef struct packed {
		logic [NUM_W-1:0] rem;
		logic [DEN_W-1:0] den;
		logic [QW-1:0]    quo;
		logic             ovf;
		logic             neg;
	} divs_t;

	// signed saturation to the value range, returns {overflow, value}
	function automatic logic [VW:0] sat_s(input logic signed [65:0] x);
		logic signed [65:0] hi;
		logic signed [65:0] lo;
		hi = 66'sd2147483647;
		lo = -66'sd2147483648;
		if (x > hi) begin
			return {1'b1, hi[VW-1:0]};
		end else if (x < lo) begin
			return {1'b1, lo[VW-1:0]};
		end
		return {1'b0, x[VW-1:0]};
	endfunction

endpackage

### hw/rtl/rwu_sqrt_cell.sv
module rwu_sqrt_cell #(
	parameter int STEP = 0
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          vld,
	input  rwu_pkg::sqs_t st,
	input  rwu_pkg::ctx_t ctx,
	output logic          vld_q,
	output rwu_pkg::sqs_t st_q,
	output rwu_pkg::ctx_t ctx_q
);
	import rwu_pkg::*;

	logic [RT_W-1:0] bit_v;
	logic [RT_W:0]   trial;
	logic            take;

	assign bit_v = RT_W'(1) << (2 * STEP);
	assign trial = {1'b0, st.root} + {1'b0, bit_v};
	assign take  = {{(RT_W + 1 - RAD_W){1'b0}}, st.rem} >= trial;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else begin
			vld_q <= vld;
		end
	end

	always_ff @(posedge clk) begin
		ctx_q <= ctx;
		if (take) begin
			st_q.rem  <= st.rem - trial[RAD_W-1:0];
			st_q.root <= (st.root >> 1) + bit_v;
		end else begin
			st_q.rem  <= st.rem;
			st_q.root <= st.root >> 1;
		end
	end

endmodule

### hw/rtl/rwu_div_cell.sv
module rwu_div_cell #(
	parameter int STEP = 0
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          vld,
	input  rwu_pkg::divs_t st,
	input  rwu_pkg::ctx_t ctx,
	output logic          vld_q,
	output rwu_pkg::divs_t st_q,
	output rwu_pkg::ctx_t ctx_q
);
	import rwu_pkg::*;

	logic [DIV_W-1:0] trial;
	logic             take;
	logic [NUM_W-1:0] rem_nxt;
	logic [QW-1:0]    quo_nxt;

	assign trial   = DIV_W'(st.den) << STEP;
	assign take    = {{(DIV_W - NUM_W){1'b0}}, st.rem} >= trial;
	assign rem_nxt = take ? st.rem - trial[NUM_W-1:0] : st.rem;
	assign quo_nxt = st.quo | (QW'(take) << STEP);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else begin
			vld_q <= vld;
		end
	end

	always_ff @(posedge clk) begin
		ctx_q       <= ctx;
		st_q.den    <= st.den;
		st_q.ovf    <= st.ovf;
		st_q.neg    <= st.neg;
		st_q.quo    <= quo_nxt;
		st_q.rem    <= rem_nxt;
	end

endmodule

### hw/rtl/rmsprop_weight_update.sv
// channel   | direction | handshake                 | payload
// ----------+-----------+---------------------------+----------------------------
// item      | in        | start & !busy             | item_t weight/momentum/ms/grad
// result    | out       | done, one cycle per beat  | result_t new values and flag
// cfg       | in        | cfg_valid & cfg_ready     | cfg_index, cfg_data
//
// one beat is taken every cycle; busy stays low, the pipeline never stalls
// a result strobes after its item passes the front-end stages, the 28-cell root chain,
// divisor stages, 32-cell divider chain and output stages, one result bit per cell
// reset clears the valid bits of every stage and loads the register defaults
// results cannot be held off, so nothing is ever waiting in the pipe
module rmsprop_weight_update (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	output logic                      busy,
	input  rwu_pkg::item_t            item,
	output logic                      done,
	output rwu_pkg::result_t          result,
	input  logic                      cfg_valid,
	output logic                      cfg_ready,
	input  logic [2:0]                cfg_index,
	input  logic [rwu_pkg::CW-1:0]    cfg_data
);
	import rwu_pkg::*;

	// configuration registers
	logic          variant_q;
	logic [CW-1:0] lr_q;
	logic [CW-1:0] beta1_q;
	logic [CW-1:0] beta2_q;
	logic [CW-1:0] eps_q;
	logic [CW-1:0] wd_q;
	logic          enable_q;

	assign cfg_ready = 1'b1;
	assign busy      = 1'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			variant_q <= 1'b0;
			lr_q      <= CW'(16777);
			beta1_q   <= CW'(15099494);
			beta2_q   <= CW'(16609444);
			eps_q     <= CW'(17);
			wd_q      <= '0;
			enable_q  <= 1'b1;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_VARIANT: variant_q <= cfg_data[0];
				CFG_LR:      lr_q      <= cfg_data;
				CFG_BETA1:   beta1_q   <= cfg_data;
				CFG_BETA2:   beta2_q   <= cfg_data;
				CFG_EPS:     eps_q     <= cfg_data;
				CFG_WD:      wd_q      <= cfg_data;
				CFG_ENABLE:  enable_q  <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// front end stage valids
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7;

	// stage 1: weight decay and momentum decay products
	item_t                item_s1;
	logic signed [57:0]   wdp_s1;
	logic signed [57:0]   bmp_s1;

	// stage 2: decayed gradient, saturated
	logic signed [VW-1:0] g_s2;
	ctx_t                 ctx_s2;
	logic signed [34:0]   gsum;
	logic [VW:0]          gsat;

	assign gsum = 35'(wdp_s1 >>> FB) + 35'($signed(item_s1.gradient_in));
	assign gsat = sat_s(66'(gsum));

	// stage 3: squared gradient and scaled gradient
	logic [63:0]          agg_s3;
	logic signed [57:0]   tp_s3;
	ctx_t                 ctx_s3;
	logic [VW-1:0]        ag;

	assign ag = g_s2[VW-1] ? (~g_s2 + VW'(1)) : g_s2;

	// stage 4: clipped square, step term, accumulating decay product
	logic [MW-1:0]        sq_s4;
	logic [55:0]          b2v_s4;
	ctx_t                 ctx_s4;
	logic [63:0]          sq_full;
	ctx_t                 ctx4_nxt;

	assign sq_full = agg_s3 >> FB;

	always_comb begin
		ctx4_nxt      = ctx_s3;
		ctx4_nxt.t    = TW'(tp_s3 >>> FB);
		ctx4_nxt.flag = ctx_s3.flag | (sq_full[63:MW] != '0);
	end

	// stage 5: leaky product and accumulating sum
	logic signed [57:0]   prod_s5;
	logic [VW:0]          vsum_s5;
	ctx_t                 ctx_s5;
	logic signed [25:0]   coef;
	logic signed [VW-1:0] vdiff;

	assign coef  = $signed({1'b0, ONE_FX}) - $signed({1'b0, beta2_q});
	assign vdiff = $signed({1'b0, sq_s4}) - $signed({1'b0, ctx_s4.v});

	// stage 6: new mean square, clamped to its range
	ctx_t                 ctx_s6;
	logic signed [34:0]   vleak;
	ctx_t                 ctx6_nxt;

	assign vleak = 35'($signed({1'b0, ctx_s5.v})) + 35'(prod_s5 >>> FB);

	always_comb begin
		ctx6_nxt = ctx_s5;
		if (!variant_q) begin
			if (vleak < 0) begin
				ctx6_nxt.vn   = '0;
				ctx6_nxt.flag = 1'b1;
			end else if (vleak > 35'sd2147483647) begin
				ctx6_nxt.vn   = '1;
				ctx6_nxt.flag = 1'b1;
			end else begin
				ctx6_nxt.vn = vleak[MW-1:0];
			end
		end else begin
			if (vsum_s5[VW:MW] != '0) begin
				ctx6_nxt.vn   = '1;
				ctx6_nxt.flag = 1'b1;
			end else begin
				ctx6_nxt.vn = vsum_s5[MW-1:0];
			end
		end
	end

	// stage 7: radicand, eps inside the root for the leaky form
	ctx_t                 ctx_s7;
	logic [VW-1:0]        rad_s7;

	// root chain
	logic                 sq_vld [0:ROOT_W];
	sqs_t                 sq_st  [0:ROOT_W];
	ctx_t                 sq_ctx [0:ROOT_W];

	assign sq_vld[0]      = v_s7;
	assign sq_st[0].rem   = {rad_s7, {FB{1'b0}}};
	assign sq_st[0].root  = '0;
	assign sq_ctx[0]      = ctx_s7;

	for (genvar j = 0; j < ROOT_W; j++) begin : g_root
		rwu_sqrt_cell #(
			.STEP (ROOT_W - 1 - j)
		) u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.vld    (sq_vld[j]),
			.st     (sq_st[j]),
			.ctx    (sq_ctx[j]),
			.vld_q  (sq_vld[j+1]),
			.st_q   (sq_st[j+1]),
			.ctx_q  (sq_ctx[j+1])
		);
	end

	// stage 8: divisor and dividend magnitude
	logic                 v_s8, v_s9;
	logic [DEN_W-1:0]     d_s8;
	logic [NUM_W-1:0]     num_s8;
	ctx_t                 ctx_s8;
	logic [ROOT_W-1:0]    root_fin;
	logic [TW-1:0]        tmag;

	assign root_fin = sq_st[ROOT_W].root[ROOT_W-1:0];
	assign tmag     = sq_ctx[ROOT_W].t[TW-1] ? TW'(-sq_ctx[ROOT_W].t) : TW'(sq_ctx[ROOT_W].t);

	// stage 9: early overflow, zero divisor or quotient would need more than the chain resolves
	divs_t                dst_s9;
	ctx_t                 ctx_s9;

	// divider chain
	logic                 dv_vld [0:QW];
	divs_t                dv_st  [0:QW];
	ctx_t                 dv_ctx [0:QW];

	assign dv_vld[0] = v_s9;
	assign dv_st[0]  = dst_s9;
	assign dv_ctx[0] = ctx_s9;

	for (genvar k = 0; k < QW; k++) begin : g_div
		rwu_div_cell #(
			.STEP (QW - 1 - k)
		) u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.vld    (dv_vld[k]),
			.st     (dv_st[k]),
			.ctx    (dv_ctx[k]),
			.vld_q  (dv_vld[k+1]),
			.st_q   (dv_st[k+1]),
			.ctx_q  (dv_ctx[k+1])
		);
	end

	// stage 10: signed, saturated quotient
	logic                 v_s10, v_s11;
	logic signed [VW-1:0] q_s10;
	ctx_t                 ctx_s10;
	divs_t                dfin;
	logic signed [VW-1:0] q_val;
	logic                 q_sat;
	ctx_t                 ctx10_nxt;

	assign dfin = dv_st[QW];

	always_comb begin
		q_sat = 1'b0;
		q_val = $signed(dfin.quo);
		if (dfin.ovf) begin
			q_sat = 1'b1;
			q_val = dfin.neg ? $signed({1'b1, {(VW-1){1'b0}}}) : $signed({1'b0, {(VW-1){1'b1}}});
		end else if (dfin.neg) begin
			if (dfin.quo > {1'b1, {(VW-1){1'b0}}}) begin
				q_sat = 1'b1;
				q_val = $signed({1'b1, {(VW-1){1'b0}}});
			end else begin
				q_val = $signed(-dfin.quo);
			end
		end else if (dfin.quo[QW-1]) begin
			q_sat = 1'b1;
			q_val = $signed({1'b0, {(VW-1){1'b1}}});
		end
	end

	always_comb begin
		ctx10_nxt      = dv_ctx[QW];
		ctx10_nxt.flag = dv_ctx[QW].flag | q_sat;
	end

	// stage 11: new momentum
	logic signed [VW-1:0] mn_s11;
	ctx_t                 ctx_s11;
	logic [VW:0]          msat;
	ctx_t                 ctx11_nxt;

	assign msat = sat_s(66'(ctx_s10.bm) + 66'(q_s10));

	always_comb begin
		ctx11_nxt      = ctx_s10;
		ctx11_nxt.flag = ctx_s10.flag | msat[VW];
	end

	// output: new weight, or the inputs when updates are off
	logic [VW:0]          wsat;

	assign wsat = sat_s(66'(ctx_s11.w) - 66'(mn_s11));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1  <= 1'b0;
			v_s2  <= 1'b0;
			v_s3  <= 1'b0;
			v_s4  <= 1'b0;
			v_s5  <= 1'b0;
			v_s6  <= 1'b0;
			v_s7  <= 1'b0;
			v_s8  <= 1'b0;
			v_s9  <= 1'b0;
			v_s10 <= 1'b0;
			v_s11 <= 1'b0;
			done  <= 1'b0;
		end else begin
			v_s1  <= start && !busy;
			v_s2  <= v_s1;
			v_s3  <= v_s2;
			v_s4  <= v_s3;
			v_s5  <= v_s4;
			v_s6  <= v_s5;
			v_s7  <= v_s6;
			v_s8  <= sq_vld[ROOT_W];
			v_s9  <= v_s8;
			v_s10 <= dv_vld[QW];
			v_s11 <= v_s10;
			done  <= v_s11;
		end
	end

	always_ff @(posedge clk) begin
		// stage 1
		item_s1 <= item;
		wdp_s1  <= $signed({1'b0, wd_q}) * $signed(item.weight_in);
		bmp_s1  <= $signed({1'b0, beta1_q}) * $signed(item.momentum_in);

		// stage 2
		g_s2        <= $signed(gsat[VW-1:0]);
		ctx_s2.w    <= item_s1.weight_in;
		ctx_s2.m    <= item_s1.momentum_in;
		ctx_s2.v    <= item_s1.mean_square_in;
		ctx_s2.vn   <= '0;
		ctx_s2.t    <= '0;
		ctx_s2.bm   <= TW'(bmp_s1 >>> FB);
		ctx_s2.flag <= gsat[VW];

		// stage 3
		agg_s3 <= ag * ag;
		tp_s3  <= g_s2 * $signed({1'b0, lr_q});
		ctx_s3 <= ctx_s2;

		// stage 4
		if (sq_full[63:MW] != '0) begin
			sq_s4 <= '1;
		end else begin
			sq_s4 <= sq_full[MW-1:0];
		end
		b2v_s4 <= beta2_q * ctx_s3.v;
		ctx_s4 <= ctx4_nxt;

		// stage 5
		prod_s5 <= vdiff * coef;
		vsum_s5 <= (VW+1)'(b2v_s4 >> FB) + (VW+1)'(sq_s4);
		ctx_s5  <= ctx_s4;

		// stage 6
		ctx_s6 <= ctx6_nxt;

		// stage 7
		ctx_s7 <= ctx_s6;
		rad_s7 <= variant_q ? VW'(ctx_s6.vn) : VW'(ctx_s6.vn) + VW'(eps_q);

		// stage 8, eps after the root for the accumulating form
		ctx_s8 <= sq_ctx[ROOT_W];
		d_s8   <= variant_q ? DEN_W'(root_fin) + DEN_W'(eps_q) : DEN_W'(root_fin);
		num_s8 <= {tmag, {FB{1'b0}}};

		// stage 9
		ctx_s9      <= ctx_s8;
		dst_s9.rem  <= num_s8;
		dst_s9.den  <= d_s8;
		dst_s9.quo  <= '0;
		dst_s9.neg  <= ctx_s8.t[TW-1];
		dst_s9.ovf  <= (d_s8 == '0) ||
			({{(DIV_W - NUM_W){1'b0}}, num_s8} >= {d_s8, {QW{1'b0}}});

		// stage 10
		q_s10   <= q_val;
		ctx_s10 <= ctx10_nxt;

		// stage 11
		mn_s11  <= $signed(msat[VW-1:0]);
		ctx_s11 <= ctx11_nxt;

		// result register
		if (enable_q) begin
			result.weight_out      <= $signed(wsat[VW-1:0]);
			result.momentum_out    <= mn_s11;
			result.mean_square_out <= ctx_s11.vn;
			result.saturated_flag  <= ctx_s11.flag | wsat[VW];
		end else begin
			result.weight_out      <= ctx_s11.w;
			result.momentum_out    <= ctx_s11.m;
			result.mean_square_out <= ctx_s11.v;
			result.saturated_flag  <= 1'b0;
		end
	end

endmodule
